// ----- hw/rtl/cfoc_pkg.sv -----
// shared types and constants for the cyclic face orientation compare block
// no dependencies; imported by the top module and the walk sequencer

package cfoc_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int LABEL_WIDTH_DEF  = 31;
    localparam int OUT_TDATA_W      = 8;

    localparam logic signed [1:0] MATCH_NONE     = 2'sb00;
    localparam logic signed [1:0] MATCH_SAME     = 2'sb01;
    localparam logic signed [1:0] MATCH_REVERSED = 2'sb11;

    typedef enum logic [2:0] {
        WALK_IDLE,
        WALK_FIND,
        WALK_FWD,
        WALK_REV,
        WALK_DONE
    } cfoc_state_t;

    // request from the loader to the walk sequencer
    typedef struct packed {
        logic start;
        logic force_zero;
    } cfoc_walk_req_t;

    // status back from the walk sequencer
    typedef struct packed {
        logic              busy;
        logic              done;
        logic signed [1:0] verdict;
    } cfoc_walk_sts_t;

endpackage

// ----- hw/rtl/cyclic_face_orientation_compare.sv -----
// loads one face label per cycle; s_tready stays low from the item closing the second face
// until its verdict moves into the output register, which is also the edge m_tvalid rises
// each walk step has a ram read phase and a phase on the shared comparator;
// for faces of n labels the walk searches, then walks forward and, on a mismatch, in reverse;
// it goes straight to done when sizes differ or a face overflowed; a held result adds stalls
// aresetn (synchronous, active low) clears counts, flags, walk state and output
// valid; label ram contents are not cleared and are used only below the counts.

module cyclic_face_orientation_compare #(
    parameter int MAX_VERTICES = cfoc_pkg::MAX_VERTICES_DEF,
    parameter int LABEL_WIDTH  = cfoc_pkg::LABEL_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((LABEL_WIDTH+7)/8)*8-1:0]    s_tdata,  // vertex_label, zero pad
    input  logic                                s_tlast,  // last_vertex
    input  logic [1:0]                          s_tuser,  // which_face, empty_face
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cfoc_pkg::OUT_TDATA_W-1:0]    m_tdata,  // match_result, zero pad
    output logic [0:0]                          m_tuser   // overflow
);
    import cfoc_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic                   accept;
    logic                   face_sel;
    logic                   empty;
    logic [LABEL_WIDTH-1:0] label;

    logic [CW-1:0]          a_cnt_reg, a_cnt_next, a_cnt_eff;
    logic [CW-1:0]          b_cnt_reg, b_cnt_next, b_cnt_eff;
    logic                   a_ovf_reg, a_ovf_next;
    logic                   b_ovf_reg, b_ovf_next;
    logic                   a_closed_reg, a_closed_next;
    logic                   b_closed_reg, b_closed_next;
    logic [LABEL_WIDTH-1:0] a0_reg, a0_next;
    logic                   ovf_pend_reg, ovf_pend_next;

    logic                   a_we, b_we;
    logic                   a_full, b_full;
    logic                   trigger;

    logic                   m_valid_reg, m_valid_next;
    logic signed [1:0]      m_verdict_reg, m_verdict_next;
    logic                   m_ovf_reg, m_ovf_next;

    logic [AW-1:0]          raddr_a, raddr_b;
    logic [LABEL_WIDTH-1:0] rdata_a, rdata_b;
    logic                   walk_ack;
    cfoc_walk_req_t         walk_req;
    cfoc_walk_sts_t         walk_sts;

    assign s_tready = !walk_sts.busy;
    assign accept   = s_tvalid && s_tready;
    assign face_sel = s_tuser[0];
    assign empty    = s_tuser[1];
    assign label    = s_tdata[LABEL_WIDTH-1:0];

    // a closed face restarts on its next item
    assign a_cnt_eff = a_closed_reg ? '0 : a_cnt_reg;
    assign b_cnt_eff = b_closed_reg ? '0 : b_cnt_reg;
    assign a_full    = (a_cnt_eff == CW'(MAX_VERTICES));
    assign b_full    = (b_cnt_eff == CW'(MAX_VERTICES));
    assign a_we      = accept && !face_sel && !empty && !a_full;
    assign b_we      = accept &&  face_sel && !empty && !b_full;
    assign trigger   = accept &&  face_sel && s_tlast;

    always_comb begin
        a_cnt_next    = a_cnt_reg;
        a_ovf_next    = a_ovf_reg;
        a_closed_next = a_closed_reg;
        b_cnt_next    = b_cnt_reg;
        b_ovf_next    = b_ovf_reg;
        b_closed_next = b_closed_reg;
        a0_next       = a0_reg;
        ovf_pend_next = ovf_pend_reg;

        if (accept && !face_sel) begin
            a_cnt_next    = a_cnt_eff + (a_we ? CW'(1) : CW'(0));
            a_ovf_next    = (a_closed_reg ? 1'b0 : a_ovf_reg) || (!empty && a_full);
            a_closed_next = s_tlast;
            if (a_we && (a_cnt_eff == '0)) begin
                a0_next = label;
            end
        end
        if (accept && face_sel) begin
            b_cnt_next    = b_cnt_eff + (b_we ? CW'(1) : CW'(0));
            b_ovf_next    = (b_closed_reg ? 1'b0 : b_ovf_reg) || (!empty && b_full);
            b_closed_next = s_tlast;
        end
        if (trigger) begin
            ovf_pend_next = a_ovf_reg || b_ovf_next;
        end
    end

    assign walk_req.start      = trigger;
    assign walk_req.force_zero = a_ovf_reg || b_ovf_next
                                 || (a_cnt_reg != b_cnt_next) || (b_cnt_next == '0);

    // output register: filled when the walk finishes and the slot is free
    assign walk_ack = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_verdict_next = m_verdict_reg;
        m_ovf_next     = m_ovf_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (walk_sts.done && walk_ack) begin
            m_valid_next   = 1'b1;
            m_verdict_next = walk_sts.verdict;
            m_ovf_next     = ovf_pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_cnt_reg    <= '0;
            b_cnt_reg    <= '0;
            a_ovf_reg    <= 1'b0;
            b_ovf_reg    <= 1'b0;
            a_closed_reg <= 1'b0;
            b_closed_reg <= 1'b0;
            ovf_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            a_cnt_reg    <= a_cnt_next;
            b_cnt_reg    <= b_cnt_next;
            a_ovf_reg    <= a_ovf_next;
            b_ovf_reg    <= b_ovf_next;
            a_closed_reg <= a_closed_next;
            b_closed_reg <= b_closed_next;
            ovf_pend_reg <= ovf_pend_next;
            m_valid_reg  <= m_valid_next;
        end
        a0_reg        <= a0_next;
        m_verdict_reg <= m_verdict_next;
        m_ovf_reg     <= m_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-2){1'b0}}, m_verdict_reg};
    assign m_tuser  = m_ovf_reg;

    cfoc_ram #(
        .WIDTH (LABEL_WIDTH),
        .DEPTH (MAX_VERTICES)
    ) u_first_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_cnt_eff[AW-1:0]),
        .wdata (label),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    cfoc_ram #(
        .WIDTH (LABEL_WIDTH),
        .DEPTH (MAX_VERTICES)
    ) u_second_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_cnt_eff[AW-1:0]),
        .wdata (label),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    cfoc_walk #(
        .MAX_VERTICES (MAX_VERTICES),
        .LABEL_WIDTH  (LABEL_WIDTH)
    ) u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (walk_req),
        .n_in        (b_cnt_next),
        .first_label (a0_reg),
        .rdata_a     (rdata_a),
        .rdata_b     (rdata_b),
        .ack         (walk_ack),
        .raddr_a     (raddr_a),
        .raddr_b     (raddr_b),
        .sts         (walk_sts)
    );

    // an overflowed face never gives a match
    a_ovf_no_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[1:0] == 2'b00)
        else $error("overflow item carries a nonzero verdict");

    a_verdict_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'b10)
        else $error("verdict code out of range");

    // a result only appears after the walk held the input side off
    a_result_after_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a preceding walk");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        a_cnt_reg <= CW'(MAX_VERTICES) && b_cnt_reg <= CW'(MAX_VERTICES))
        else $error("face count beyond store depth");

endmodule

// ----- hw/rtl/cfoc_ram.sv -----
// generic simple dual-port ram, one write port and one registered read port
// no package dependencies

module cfoc_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/cfoc_walk.sv -----
// walk sequencer: finds the alignment point, then checks forward and reverse
// order with one shared label comparator; depends on cfoc_pkg

module cfoc_walk #(
    parameter int MAX_VERTICES = cfoc_pkg::MAX_VERTICES_DEF,
    parameter int LABEL_WIDTH  = cfoc_pkg::LABEL_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cfoc_pkg::cfoc_walk_req_t          req,
    input  logic [$clog2(MAX_VERTICES+1)-1:0] n_in,
    input  logic [LABEL_WIDTH-1:0]            first_label,
    input  logic [LABEL_WIDTH-1:0]            rdata_a,
    input  logic [LABEL_WIDTH-1:0]            rdata_b,
    input  logic                              ack,
    output logic [$clog2(MAX_VERTICES)-1:0]   raddr_a,
    output logic [$clog2(MAX_VERTICES)-1:0]   raddr_b,
    output cfoc_pkg::cfoc_walk_sts_t          sts
);
    import cfoc_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    cfoc_state_t       state_reg, state_next;
    logic              phase_reg, phase_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [AW-1:0]     start_reg, start_next;
    logic [CW-1:0]     n_reg, n_next;
    logic signed [1:0] verdict_reg, verdict_next;

    logic [CW-1:0]          nm1_wide;
    logic [AW-1:0]          nm1;
    logic [AW-1:0]          ptr_inc;
    logic [AW-1:0]          ptr_dec;
    logic [AW-1:0]          start_dec;
    logic [LABEL_WIDTH-1:0] cmp_lhs;
    logic                   cmp_eq;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= WALK_IDLE;
            phase_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
        end
        idx_reg     <= idx_next;
        ptr_reg     <= ptr_next;
        start_reg   <= start_next;
        n_reg       <= n_next;
        verdict_reg <= verdict_next;
    end

    assign nm1_wide  = n_reg - CW'(1);
    assign nm1       = nm1_wide[AW-1:0];
    assign ptr_inc   = (ptr_reg == nm1) ? '0 : ptr_reg + AW'(1);
    assign ptr_dec   = (ptr_reg == '0) ? nm1 : ptr_reg - AW'(1);
    assign start_dec = (start_reg == '0) ? nm1 : start_reg - AW'(1);

    // the one comparator: first label against the second face while searching,
    // otherwise first face entry against second face entry
    assign cmp_lhs = (state_reg == WALK_FIND) ? first_label : rdata_a;
    assign cmp_eq  = (cmp_lhs == rdata_b);

    assign raddr_a = idx_reg[AW-1:0];
    assign raddr_b = ptr_reg;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        ptr_next     = ptr_reg;
        start_next   = start_reg;
        n_next       = n_reg;
        verdict_next = verdict_reg;

        case (state_reg)
            WALK_IDLE: begin
                if (req.start) begin
                    n_next     = n_in;
                    ptr_next   = '0;
                    phase_next = 1'b0;
                    if (req.force_zero) begin
                        verdict_next = MATCH_NONE;
                        state_next   = WALK_DONE;
                    end else begin
                        state_next = WALK_FIND;
                    end
                end
            end
            WALK_FIND: begin
                if (!phase_reg) begin
                    phase_next = 1'b1;
                end else begin
                    phase_next = 1'b0;
                    if (cmp_eq) begin
                        start_next = ptr_reg;
                        ptr_next   = ptr_inc;
                        idx_next   = CW'(1);
                        state_next = WALK_FWD;
                    end else if (ptr_reg == nm1) begin
                        verdict_next = MATCH_NONE;
                        state_next   = WALK_DONE;
                    end else begin
                        ptr_next = ptr_reg + AW'(1);
                    end
                end
            end
            WALK_FWD: begin
                if (!phase_reg) begin
                    if (idx_reg == n_reg) begin
                        verdict_next = MATCH_SAME;
                        state_next   = WALK_DONE;
                    end else begin
                        phase_next = 1'b1;
                    end
                end else begin
                    phase_next = 1'b0;
                    if (cmp_eq) begin
                        idx_next = idx_reg + CW'(1);
                        ptr_next = ptr_inc;
                    end else begin
                        idx_next   = CW'(1);
                        ptr_next   = start_dec;
                        state_next = WALK_REV;
                    end
                end
            end
            WALK_REV: begin
                if (!phase_reg) begin
                    if (idx_reg == n_reg) begin
                        verdict_next = MATCH_REVERSED;
                        state_next   = WALK_DONE;
                    end else begin
                        phase_next = 1'b1;
                    end
                end else begin
                    phase_next = 1'b0;
                    if (cmp_eq) begin
                        idx_next = idx_reg + CW'(1);
                        ptr_next = ptr_dec;
                    end else begin
                        verdict_next = MATCH_NONE;
                        state_next   = WALK_DONE;
                    end
                end
            end
            WALK_DONE: begin
                if (ack) begin
                    state_next = WALK_IDLE;
                end
            end
            default: begin
                state_next = WALK_IDLE;
            end
        endcase
    end

    assign sts.busy    = (state_reg != WALK_IDLE);
    assign sts.done    = (state_reg == WALK_DONE);
    assign sts.verdict = verdict_reg;

endmodule
